// File: rtl/kmuf_pkg.sv
package kmuf_pkg;

   // Store geometry
   localparam int MAX_VERTICES = 1024;
   localparam int VTX_BITS     = $clog2(MAX_VERTICES);
   localparam int RANK_BITS    = 4;
   localparam logic [RANK_BITS-1:0] RANK_MAX = '1;

   // Field widths
   localparam int WEIGHT_BITS = 16;
   localparam int TOTAL_BITS  = 26;
   localparam int COUNT_BITS  = VTX_BITS;
   localparam int VCOUNT_BITS = VTX_BITS + 1;
   localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = VCOUNT_BITS'(MAX_VERTICES);

   // Register port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-3:0] REG_VERTEX_COUNT = '0;

   // One store entry: rank and parent pointer of a vertex
   typedef struct packed {
      logic [RANK_BITS-1:0] rank;
      logic [VTX_BITS-1:0]  parent;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

endpackage

// File: rtl/kmuf_req_if.sv
interface kmuf_req_if;
   import kmuf_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   start_graph;
   logic [VTX_BITS-1:0]    vertex_a;
   logic [VTX_BITS-1:0]    vertex_b;
   logic [WEIGHT_BITS-1:0] weight;

   modport source (output valid, start_graph, vertex_a, vertex_b, weight, input ready);
   modport sink   (input valid, start_graph, vertex_a, vertex_b, weight, output ready);
endinterface

// File: rtl/kmuf_rsp_if.sv
interface kmuf_rsp_if;
   import kmuf_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  accepted;
   logic                  bad_vertex;
   logic [TOTAL_BITS-1:0] total_weight;
   logic [COUNT_BITS-1:0] edges_taken;
   logic                  tree_complete;

   modport source (output valid, accepted, bad_vertex, total_weight, edges_taken,
                   tree_complete, input ready);
   modport sink   (input valid, accepted, bad_vertex, total_weight, edges_taken,
                   tree_complete, output ready);
endinterface

// File: rtl/kmuf_ram.sv
module kmuf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/kruskal_mst_union_find.sv
// Channel  | Direction | Handshake     | Payload
// req_if   | in        | valid / ready | start_graph, vertex_a, vertex_b, weight
// rsp_if   | out       | valid / ready | accepted, bad_vertex, total_weight,
//          |           |               | edges_taken, tree_complete
// csr_*    | in        | APB write/read| vertex_count at byte address 0
//
// One edge at a time. Each edge is screened, then each endpoint in turn is walked up
// to its root and its path pointed straight at that root, then the roots are joined
// by rank; a tie raises the surviving root's rank unless at its top. A bad endpoint,
// a finished tree or a shared root skips to the result. Union by rank keeps each
// depth at most log2(vertex_count). The parent/rank memory has a single-read, single-write port.
// Reset, and every beat with start_graph set, first sweeps all 1024 entries,
// one per cycle, before the edge is taken up; no beat is accepted meanwhile.
// A finished beat waits in the output register while the next edge is accepted.
module kruskal_mst_union_find (
   input  logic                              clock,
   input  logic                              reset,
   kmuf_req_if.sink                          req_if,
   kmuf_rsp_if.source                        rsp_if,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [kmuf_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [kmuf_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [kmuf_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import kmuf_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_EVAL, S_FIND, S_COMP, S_TURN, S_UNION, S_RANK, S_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [VTX_BITS-1:0]     clr_cnt_ff, clr_cnt_in;
   logic                    clr_ret_ff, clr_ret_in;
   logic [VCOUNT_BITS-1:0]  vcount_ff, vcount_in;
   logic [VTX_BITS-1:0]     va_ff, va_in, vb_ff, vb_in;
   logic [WEIGHT_BITS-1:0]  w_ff, w_in;
   logic [VCOUNT_BITS-1:0]  n_ff, n_in;
   logic [COUNT_BITS-1:0]   needed_ff, needed_in;
   logic                    side_ff, side_in;
   logic [VTX_BITS-1:0]     cur_ff, cur_in;
   logic [VTX_BITS-1:0]     root_ff, root_in;
   logic [VTX_BITS-1:0]     ra_ff, ra_in;
   logic [RANK_BITS-1:0]    rank_a_ff, rank_a_in, rank_b_ff, rank_b_in;
   logic [TOTAL_BITS-1:0]   total_ff, total_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    acc_ff, acc_in, bad_ff, bad_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_acc_ff, rsp_acc_in, rsp_bad_ff, rsp_bad_in;
   logic [TOTAL_BITS-1:0]   rsp_total_ff, rsp_total_in;
   logic [COUNT_BITS-1:0]   rsp_count_ff, rsp_count_in;
   logic                    rsp_done_ff, rsp_done_in;

   logic                    wr_en;
   logic [VTX_BITS-1:0]     wr_addr;
   entry_type               wr_ent;
   entry_type               rd_ent;
   logic [ENTRY_BITS-1:0]   rd_raw;
   logic                    csr_wr;
   logic                    csr_hit;
   logic [VCOUNT_BITS-1:0]  n_eff;
   logic [TOTAL_BITS:0]     sum;

   // Parent/rank store
   kmuf_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_VERTICES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_addr (cur_in),
      .rd_data (rd_raw)
   );

   assign rd_ent = entry_type'(rd_raw);

   // Register port decode
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_BITS-1:2] == REG_VERTEX_COUNT);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_hit;
   assign csr_prdata = csr_hit ? CSR_DATA_BITS'(vcount_ff) : '0;

   // Clamp the vertex count to the store depth
   assign n_eff = (vcount_ff > VCOUNT_BITS'(MAX_VERTICES)) ?
                  VCOUNT_BITS'(MAX_VERTICES) : vcount_ff;

   // Saturating running total
   assign sum = {1'b0, total_ff} + (TOTAL_BITS+1)'(w_ff);

   assign req_if.ready         = (state_ff == S_IDLE);
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.accepted      = rsp_acc_ff;
   assign rsp_if.bad_vertex    = rsp_bad_ff;
   assign rsp_if.total_weight  = rsp_total_ff;
   assign rsp_if.edges_taken   = rsp_count_ff;
   assign rsp_if.tree_complete = rsp_done_ff;

   // Next state
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_ret_in   = clr_ret_ff;
      vcount_in    = vcount_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      w_in         = w_ff;
      n_in         = n_ff;
      needed_in    = needed_ff;
      side_in      = side_ff;
      cur_in       = cur_ff;
      root_in      = root_ff;
      ra_in        = ra_ff;
      rank_a_in    = rank_a_ff;
      rank_b_in    = rank_b_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_total_in = rsp_total_ff;
      rsp_count_in = rsp_count_ff;
      rsp_done_in  = rsp_done_ff;
      wr_en        = 1'b0;
      wr_addr      = cur_ff;
      wr_ent       = '0;

      // Drop the output beat once taken
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr) begin
         vcount_in = csr_pwdata[VCOUNT_BITS-1:0];
      end

      unique case (state_ff)
         S_CLEAR: begin
            // Sweep the store back to identity, rank zero
            wr_en       = 1'b1;
            wr_addr     = clr_cnt_ff;
            wr_ent      = '{rank: '0, parent: clr_cnt_ff};
            clr_cnt_in  = clr_cnt_ff + VTX_BITS'(1);
            if (clr_cnt_ff == VTX_BITS'(MAX_VERTICES - 1)) begin
               state_in = clr_ret_ff ? S_EVAL : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_if.valid) begin
               va_in     = req_if.vertex_a;
               vb_in     = req_if.vertex_b;
               w_in      = req_if.weight;
               n_in      = n_eff;
               needed_in = (n_eff == '0) ? '0 : COUNT_BITS'(n_eff - VCOUNT_BITS'(1));
               acc_in    = 1'b0;
               bad_in    = 1'b0;
               if (req_if.start_graph) begin
                  total_in   = '0;
                  count_in   = '0;
                  clr_cnt_in = '0;
                  clr_ret_in = 1'b1;
                  state_in   = S_CLEAR;
               end else begin
                  state_in = S_EVAL;
               end
            end
         end
         S_EVAL: begin
            // Screen bad endpoints and a finished tree, else start the first find
            if (({1'b0, va_ff} >= n_ff) || ({1'b0, vb_ff} >= n_ff)) begin
               bad_in   = 1'b1;
               state_in = S_EMIT;
            end else if (count_ff >= needed_ff) begin
               state_in = S_EMIT;
            end else begin
               side_in  = 1'b0;
               cur_in   = va_ff;
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            // Walk parent pointers up to the root
            if (rd_ent.parent == cur_ff) begin
               root_in = cur_ff;
               if (side_ff) begin
                  rank_b_in = rd_ent.rank;
                  cur_in    = vb_ff;
               end else begin
                  ra_in     = cur_ff;
                  rank_a_in = rd_ent.rank;
                  cur_in    = va_ff;
               end
               state_in = S_COMP;
            end else begin
               cur_in = rd_ent.parent;
            end
         end
         S_COMP: begin
            // Point every vertex on the path straight at the root
            if (cur_ff != root_ff) begin
               wr_en   = 1'b1;
               wr_addr = cur_ff;
               wr_ent  = '{rank: rd_ent.rank, parent: root_ff};
            end
            if (rd_ent.parent == root_ff) begin
               state_in = side_ff ? S_UNION : S_TURN;
               side_in  = 1'b1;
            end else begin
               cur_in = rd_ent.parent;
            end
         end
         S_TURN: begin
            // Start the second find after the last path write has landed
            cur_in   = vb_ff;
            state_in = S_FIND;
         end
         S_UNION: begin
            // Join by rank, count the edge and add its weight, unless both ends share a root
            if (ra_ff == root_ff) begin
               state_in = S_EMIT;
            end else begin
               wr_en    = 1'b1;
               acc_in   = 1'b1;
               count_in = count_ff + COUNT_BITS'(1);
               total_in = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
               state_in = S_EMIT;
               if (rank_a_ff < rank_b_ff) begin
                  wr_addr = ra_ff;
                  wr_ent  = '{rank: rank_a_ff, parent: root_ff};
               end else begin
                  wr_addr = root_ff;
                  wr_ent  = '{rank: rank_b_ff, parent: ra_ff};
                  if ((rank_a_ff == rank_b_ff) && (rank_a_ff != RANK_MAX)) begin
                     state_in = S_RANK;
                  end
               end
            end
         end
         S_RANK: begin
            // Raise the rank of the surviving root
            wr_en    = 1'b1;
            wr_addr  = ra_ff;
            wr_ent   = '{rank: rank_a_ff + RANK_BITS'(1), parent: ra_ff};
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // Load the output register once it is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = acc_ff;
               rsp_bad_in   = bad_ff;
               rsp_total_in = total_ff;
               rsp_count_in = count_ff;
               rsp_done_in  = (count_ff >= needed_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         clr_ret_ff   <= 1'b0;
         vcount_ff    <= VCOUNT_RESET;
         total_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_ret_ff   <= clr_ret_in;
         vcount_ff    <= vcount_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      va_ff        <= va_in;
      vb_ff        <= vb_in;
      w_ff         <= w_in;
      n_ff         <= n_in;
      needed_ff    <= needed_in;
      side_ff      <= side_in;
      cur_ff       <= cur_in;
      root_ff      <= root_in;
      ra_ff        <= ra_in;
      rank_a_ff    <= rank_a_in;
      rank_b_ff    <= rank_b_in;
      acc_ff       <= acc_in;
      bad_ff       <= bad_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_bad_ff   <= rsp_bad_in;
      rsp_total_ff <= rsp_total_in;
      rsp_count_ff <= rsp_count_in;
      rsp_done_ff  <= rsp_done_in;
   end

endmodule

// File: sim/kmuf_mst_checker.sv
`timescale 1ns / 100ps

module kmuf_mst_checker (
   input  logic                               clock,
   input  logic                               reset,
   kmuf_req_if                                req,
   kmuf_rsp_if                                rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [kmuf_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [kmuf_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic [kmuf_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   input  logic                               csr_pready,
   input  logic                               wrap_up,
   output int                                 fail_count
);
   import kmuf_pkg::*;

   localparam logic [TOTAL_BITS:0] SUM_CAP = {1'b0, {TOTAL_BITS{1'b1}}};

   typedef struct packed {
      logic                  accepted;
      logic                  bad_vertex;
      logic [TOTAL_BITS-1:0] total_weight;
      logic [COUNT_BITS-1:0] edges_taken;
      logic                  tree_complete;
   } edge_outcome_type;

   // Forest of the current graph and its running tallies
   logic [VTX_BITS-1:0]    up_link [MAX_VERTICES];
   logic [RANK_BITS-1:0]   height  [MAX_VERTICES];
   logic [TOTAL_BITS-1:0]  sum_w;
   logic [VCOUNT_BITS-1:0] taken;
   logic [VCOUNT_BITS-1:0] vcount;

   edge_outcome_type edge_outcomes [$];
   int unsigned      beats_checked;
   logic             wrapped;

   initial fail_count = 0;

   task automatic report(input string what, input longint unsigned seen,
                         input longint unsigned wanted);
      fail_count++;
      $display("[%0t] mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
               $time, beats_checked, what, seen, wanted);
   endtask

   function automatic void clear_forest();
      for (int i = 0; i < MAX_VERTICES; i++) begin
         up_link[i] = VTX_BITS'(i);
         height[i]  = '0;
      end
      sum_w = '0;
      taken = '0;
   endfunction

   // Walk to the root, then point every vertex on the path straight at it
   function automatic logic [VTX_BITS-1:0] find_root(input logic [VTX_BITS-1:0] v);
      logic [VTX_BITS-1:0] r;
      logic [VTX_BITS-1:0] nxt;
      logic [VTX_BITS-1:0] cur;
      r   = v;
      cur = v;
      while (up_link[r] != r)
         r = up_link[r];
      while (cur != r) begin
         nxt = up_link[cur];
         up_link[cur] = r;
         cur = nxt;
      end
      return r;
   endfunction

   // Fold one edge into the forest and return the result it should yield
   function automatic edge_outcome_type fold_edge(input logic start,
                                                  input logic [VTX_BITS-1:0] a,
                                                  input logic [VTX_BITS-1:0] b,
                                                  input logic [WEIGHT_BITS-1:0] w);
      logic [VCOUNT_BITS-1:0] n;
      logic [VCOUNT_BITS-1:0] needed;
      logic [VTX_BITS-1:0]    ra;
      logic [VTX_BITS-1:0]    rb;
      logic [TOTAL_BITS:0]    s;
      edge_outcome_type       res;
      n = vcount;
      if (n > VCOUNT_BITS'(MAX_VERTICES))
         n = VCOUNT_BITS'(MAX_VERTICES);
      needed = (n == '0) ? '0 : n - VCOUNT_BITS'(1);
      if (start)
         clear_forest();
      res = '0;
      if (({1'b0, a} >= n) || ({1'b0, b} >= n)) begin
         res.bad_vertex = 1'b1;
      end else if (taken < needed) begin
         ra = find_root(a);
         rb = find_root(b);
         if (ra != rb) begin
            // union by rank, rank saturating at its top value
            if (height[ra] < height[rb]) begin
               up_link[ra] = rb;
            end else if (height[ra] > height[rb]) begin
               up_link[rb] = ra;
            end else begin
               up_link[rb] = ra;
               if (height[ra] < RANK_MAX)
                  height[ra]++;
            end
            res.accepted = 1'b1;
            taken = taken + VCOUNT_BITS'(1);
            s = {1'b0, sum_w} + (TOTAL_BITS+1)'(w);
            sum_w = (s > SUM_CAP) ? SUM_CAP[TOTAL_BITS-1:0] : s[TOTAL_BITS-1:0];
         end
      end
      res.total_weight  = sum_w;
      res.edges_taken   = taken[COUNT_BITS-1:0];
      res.tree_complete = (taken >= needed);
      return res;
   endfunction

   always @(posedge clock) begin
      edge_outcome_type seen;
      edge_outcome_type want;
      if (reset) begin
         clear_forest();
         vcount = VCOUNT_RESET;
         edge_outcomes.delete();
         beats_checked = 0;
         wrapped = 1'b0;
      end else begin
         // compare a result beat with the oldest expectation
         if (rsp.valid && rsp.ready) begin
            seen = '{rsp.accepted, rsp.bad_vertex, rsp.total_weight, rsp.edges_taken,
                     rsp.tree_complete};
            if (edge_outcomes.size() == 0) begin
               report("result with nothing pending", 1, 0);
            end else begin
               want = edge_outcomes.pop_front();
               if (seen.accepted !== want.accepted)
                  report("accepted", seen.accepted, want.accepted);
               if (seen.bad_vertex !== want.bad_vertex)
                  report("bad_vertex", seen.bad_vertex, want.bad_vertex);
               if (seen.total_weight !== want.total_weight)
                  report("total_weight", seen.total_weight, want.total_weight);
               if (seen.edges_taken !== want.edges_taken)
                  report("edges_taken", seen.edges_taken, want.edges_taken);
               if (seen.tree_complete !== want.tree_complete)
                  report("tree_complete", seen.tree_complete, want.tree_complete);
            end
            beats_checked++;
         end

         // predict each accepted edge beat
         if (req.valid && req.ready)
            edge_outcomes = {edge_outcomes, fold_edge(req.start_graph, req.vertex_a,
                                                      req.vertex_b, req.weight)};

         // track register writes, check register reads
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[CSR_ADDR_BITS-1:2] == REG_VERTEX_COUNT) begin
            if (csr_pwrite)
               vcount = csr_pwdata[VCOUNT_BITS-1:0];
            else if (csr_prdata !== CSR_DATA_BITS'(vcount))
               report("vertex_count read", csr_prdata, vcount);
         end

         // flag whatever is still owed at the end
         if (wrap_up && !wrapped) begin
            wrapped = 1'b1;
            if (edge_outcomes.size() != 0)
               report("results never delivered", edge_outcomes.size(), 0);
         end
      end
   end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
   import kmuf_pkg::*;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int HOLD_CYCLES  = 400;
   localparam logic [CSR_ADDR_BITS-1:0] VCOUNT_ADDR = {REG_VERTEX_COUNT, 2'b00};

   logic clock;
   logic reset;

   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   logic        calm;
   logic        hold_rsp;
   logic        wrap_up;
   int          fail_count;
   int unsigned sent;
   int unsigned got;
   int unsigned graphs;
   int unsigned writes;
   int unsigned cycles;

   kmuf_req_if req_bus ();
   kmuf_rsp_if rsp_bus ();

   kruskal_mst_union_find u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   kmuf_mst_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .wrap_up     (wrap_up),
      .fail_count  (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Give up on a hung run
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d of %0d results back", cycles, got, sent);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side: random stalls, none while calm, stalled throughout the hold-off
   initial got = 0;
   always @(posedge clock) begin
      if (rsp_bus.valid && rsp_bus.ready)
         got++;
      if (reset || hold_rsp)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= calm || ($urandom_range(99) >= 9);
   end

   // Hold off the result side for a long stretch once traffic is flowing
   initial begin
      hold_rsp <= 1'b0;
      wait (sent >= 250);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   task automatic send_edge(input logic start, input int unsigned a, input int unsigned b,
                            input int unsigned w);
      while (!calm && $urandom_range(99) < 9) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.start_graph <= start;
      req_bus.vertex_a    <= a[VTX_BITS-1:0];
      req_bus.vertex_b    <= b[VTX_BITS-1:0];
      req_bus.weight      <= w[WEIGHT_BITS-1:0];
      do @(posedge clock); while (!req_bus.ready);
      sent++;
      if (start)
         graphs++;
   endtask

   task automatic csr_access(input logic wr, input int unsigned data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= VCOUNT_ADDR;
      csr_pwdata  <= CSR_DATA_BITS'(data);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Drain the block, then write the vertex count and read it back
   task automatic set_vcount(input int unsigned n);
      req_bus.valid <= 1'b0;
      wait (got == sent);
      repeat (2) @(posedge clock);
      csr_access(1'b1, n);
      csr_access(1'b0, 0);
      writes++;
   endtask

   initial begin
      int unsigned kind;
      int unsigned n;
      int unsigned cur;
      int unsigned edges;
      int unsigned step;
      int unsigned w;
      int unsigned a;
      int unsigned b;
      int unsigned big_done;

      reset               = 1'b1;
      calm                = 1'b0;
      wrap_up             = 1'b0;
      sent                = 0;
      graphs              = 0;
      writes              = 0;
      big_done            = 0;
      req_bus.valid       <= 1'b0;
      req_bus.start_graph <= 1'b0;
      req_bus.vertex_a    <= '0;
      req_bus.vertex_b    <= '0;
      req_bus.weight      <= '0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: four vertices, same tree, self loop, bad endpoints, completion
      set_vcount(4);
      send_edge(1'b1, 0, 1, 0);
      send_edge(1'b0, 1, 0, 5);
      send_edge(1'b0, 2, 2, 6);
      send_edge(1'b0, 0, 4, 7);
      send_edge(1'b0, 1023, 0, 8);
      send_edge(1'b0, 2, 3, 9);
      send_edge(1'b0, 3, 0, 10);
      send_edge(1'b0, 2, 1, 11);
      send_edge(1'b0, 9, 1, 12);
      // grow the vertex count mid-graph: the forest carries over
      set_vcount(8);
      send_edge(1'b0, 5, 6, 20);
      send_edge(1'b0, 7, 4, 65535);
      send_edge(1'b0, 4, 5, 65535);
      // zero vertices: everything is bad, tree counts as complete
      set_vcount(0);
      send_edge(1'b1, 0, 0, 0);
      // one vertex: nothing needed
      set_vcount(1);
      send_edge(1'b1, 0, 0, 1);
      // above the store size: capped
      set_vcount(2047);
      send_edge(1'b1, 1023, 0, 65535);
      send_edge(1'b0, 1023, 1023, 65535);
      send_edge(1'b0, 512, 1022, 65535);
      set_vcount(2);
      send_edge(1'b1, 1, 0, 3);
      send_edge(1'b0, 0, 1, 4);
      send_edge(1'b0, 2, 1, 5);

      // Random graphs: mostly well-formed sorted edge lists, some noise
      while (sent < 1040) begin
         calm <= (sent >= 420 && sent < 620);
         kind = $urandom_range(99);
         if (kind < 8) begin
            // noise: any register value, unsorted weights, stray starts
            set_vcount($urandom_range(2047));
            repeat (15)
               send_edge($urandom_range(9) == 0, $urandom_range(1023), $urandom_range(1023),
                         $urandom_range(65535));
         end else begin
            if (kind < 14 && big_done < 2) begin
               n = 1024;
               edges = 120;
               big_done++;
            end else if (kind < 35) begin
               n = $urandom_range(25, 64);
               edges = 2 * n + $urandom_range(n);
            end else begin
               n = $urandom_range(2, 24);
               edges = 3 * n;
            end
            cur = n;
            set_vcount((n == 1024 && $urandom_range(1)) ? $urandom_range(1025, 2047) : n);
            step = 65535 / edges;
            w = $urandom_range(200);
            for (int i = 0; i < edges && sent < 1050; i++) begin
               // now and then move the vertex count in mid-graph
               if (i == edges / 2 && $urandom_range(5) == 0) begin
                  cur = $urandom_range(1, (2 * n > 1024) ? 1024 : 2 * n);
                  set_vcount(cur);
               end
               a = ($urandom_range(19) == 0) ? $urandom_range(1023) : $urandom_range(n - 1);
               b = ($urandom_range(19) == 0) ? $urandom_range(1023) : $urandom_range(n - 1);
               w = w + $urandom_range(2 * step);
               if (w > 65535)
                  w = 65535;
               send_edge(i == 0, a, b, w);
            end
         end
      end
      calm <= 1'b0;
      req_bus.valid <= 1'b0;

      // Wait out the last results, then settle the verdict
      wait (got == sent);
      repeat (60) @(posedge clock);
      wrap_up <= 1'b1;
      repeat (2) @(posedge clock);
      $display("ran %0d edges in %0d graphs with %0d vertex-count settings,", sent, graphs,
               writes);
      $display("compared %0d results, across a %0d-cycle output hold-off", got, HOLD_CYCLES);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: filelist.f
rtl/kmuf_pkg.sv
rtl/kmuf_req_if.sv
rtl/kmuf_rsp_if.sv
rtl/kmuf_ram.sv
rtl/kruskal_mst_union_find.sv
sim/kmuf_mst_checker.sv
sim/tb.sv
